[rtl/core/rpyt_pkg.sv]
// ----------------------------------------------------------------------------
// rpyt_pkg: shared types and constants
// Request structs, CORDIC arctangent table and fixed-point constants for the
// roll/pitch/yaw to homogeneous transform core.
// ----------------------------------------------------------------------------
package rpyt_pkg;

    localparam int CordicStagesDefault = 16;
    localparam int AtanEntries         = 24;
    localparam int AngW                = 34;   // Q2.30 plus headroom
    localparam int TrigW               = 16;   // Q1.14 sine and cosine

    localparam logic signed [AngW-1:0] AngPi      = 34'sd3373259426;
    localparam logic signed [AngW-1:0] AngHalfPi  = 34'sd1686629713;
    localparam logic signed [AngW-1:0] CordicInvK = 34'sd652032874;
    localparam logic signed [TrigW-1:0] Q14One    = 16'sd16384;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } rpyt_in_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } rpyt_out_t;

    typedef struct packed {
        logic signed [TrigW-1:0] s;
        logic signed [TrigW-1:0] c;
    } rpyt_sc_t;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [AngW-1:0] atan_q30(input int i);
        case (i)
            0:  atan_q30 = 34'sd843314857;
            1:  atan_q30 = 34'sd497837829;
            2:  atan_q30 = 34'sd263043837;
            3:  atan_q30 = 34'sd133525159;
            4:  atan_q30 = 34'sd67021687;
            5:  atan_q30 = 34'sd33543516;
            6:  atan_q30 = 34'sd16775851;
            7:  atan_q30 = 34'sd8388437;
            8:  atan_q30 = 34'sd4194283;
            9:  atan_q30 = 34'sd2097149;
            10: atan_q30 = 34'sd1048576;
            11: atan_q30 = 34'sd524288;
            12: atan_q30 = 34'sd262144;
            13: atan_q30 = 34'sd131072;
            14: atan_q30 = 34'sd65536;
            15: atan_q30 = 34'sd32768;
            16: atan_q30 = 34'sd16384;
            17: atan_q30 = 34'sd8192;
            18: atan_q30 = 34'sd4096;
            19: atan_q30 = 34'sd2048;
            20: atan_q30 = 34'sd1024;
            21: atan_q30 = 34'sd512;
            22: atan_q30 = 34'sd256;
            default: atan_q30 = 34'sd128;
        endcase
    endfunction

endpackage

[rtl/core/rpyt_cordic_lane.sv]
// ----------------------------------------------------------------------------
// rpyt_cordic_lane: pipelined sine and cosine of one angle
// Quadrant fold, one register stage per CORDIC iteration, then rounding and
// saturation to Q1.14. Advances whenever en is high.
// ----------------------------------------------------------------------------
module rpyt_cordic_lane
    import rpyt_pkg::*;
#(
    parameter int STAGES = CordicStagesDefault
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [15:0]      angle,
    output rpyt_sc_t                sc
);

    localparam int NS = (STAGES > AtanEntries) ? AtanEntries : STAGES;

    logic signed [AngW-1:0] x_reg [0:NS];
    logic signed [AngW-1:0] y_reg [0:NS];
    logic signed [AngW-1:0] z_reg [0:NS];
    logic                   neg_reg [0:NS];
    rpyt_sc_t               sc_reg;

    // Fold the angle into [-pi/2, pi/2].
    logic signed [AngW-1:0] a_wide;
    logic signed [AngW-1:0] a_fold;
    logic                   a_neg;
    always_comb begin
        a_wide = AngW'(signed'({{(AngW-33){angle[15]}}, angle, 17'd0}));
        a_neg  = 1'b0;
        a_fold = a_wide;
        if (a_wide > AngHalfPi) begin
            a_fold = a_wide - AngPi;
            a_neg  = 1'b1;
        end else if (a_wide < -AngHalfPi) begin
            a_fold = a_wide + AngPi;
            a_neg  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= CordicInvK;
            y_reg[0]   <= '0;
            z_reg[0]   <= a_fold;
            neg_reg[0] <= a_neg;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < NS; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][AngW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // Round to Q1.14, saturate, restore the folded sign.
    function automatic logic signed [TrigW-1:0] rnd(input logic signed [AngW-1:0] v,
                                                     input logic neg);
        logic signed [AngW-1:0] t;
        logic signed [TrigW-1:0] q;
        t = (v + AngW'(32768)) >>> 16;
        if (t > AngW'(Q14One))       q = Q14One;
        else if (t < -AngW'(Q14One)) q = -Q14One;
        else                         q = t[TrigW-1:0];
        rnd = neg ? -q : q;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg.c <= rnd(x_reg[NS], neg_reg[NS]);
            sc_reg.s <= rnd(y_reg[NS], neg_reg[NS]);
        end
    end

    assign sc = sc_reg;

endmodule

[rtl/core/rpyt_merge.sv]
// ----------------------------------------------------------------------------
// rpyt_merge: combine the three lanes into the rotation matrix
// Stage 1 forms two-factor products, stage 2 the three-factor terms, stage 3
// the sums with rounding and saturation. Advances whenever en is high.
// ----------------------------------------------------------------------------
module rpyt_merge
    import rpyt_pkg::*;
(
    input  logic      aclk,
    input  logic      en,
    input  rpyt_sc_t  sc_r,
    input  rpyt_sc_t  sc_p,
    input  rpyt_sc_t  sc_y,
    output logic signed [TrigW-1:0] r_out [0:8]
);

    // Products of two Q1.14 values are Q2.28 and fit 30 bits.
    logic signed [29:0] cycp_reg, sycp_reg, cysp_reg, sysp_reg;
    logic signed [29:0] sycr_reg, sysr_reg, cycr_reg, cysr_reg;
    logic signed [29:0] cpsr_reg, cpcr_reg;
    logic signed [TrigW-1:0] sr_reg, cr_reg, sp_reg;
    logic signed [29:0] cycp2_reg, sycp2_reg, sycr2_reg, sysr2_reg;
    logic signed [29:0] cycr2_reg, cysr2_reg, cpsr2_reg, cpcr2_reg;
    logic signed [TrigW-1:0] sp2_reg;
    logic signed [45:0] t1_reg, t2_reg, t4_reg, t5_reg;
    logic signed [TrigW-1:0] r_reg [0:8];

    always_ff @(posedge aclk) begin
        if (en) begin
            cycp_reg <= 30'(sc_y.c * sc_p.c);
            sycp_reg <= 30'(sc_y.s * sc_p.c);
            cysp_reg <= 30'(sc_y.c * sc_p.s);
            sysp_reg <= 30'(sc_y.s * sc_p.s);
            sycr_reg <= 30'(sc_y.s * sc_r.c);
            sysr_reg <= 30'(sc_y.s * sc_r.s);
            cycr_reg <= 30'(sc_y.c * sc_r.c);
            cysr_reg <= 30'(sc_y.c * sc_r.s);
            cpsr_reg <= 30'(sc_p.c * sc_r.s);
            cpcr_reg <= 30'(sc_p.c * sc_r.c);
            sr_reg   <= sc_r.s;
            cr_reg   <= sc_r.c;
            sp_reg   <= sc_p.s;
        end
    end

    // Three-factor terms, Q3.42.
    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg    <= 46'(cysp_reg * sr_reg);
            t2_reg    <= 46'(cysp_reg * cr_reg);
            t4_reg    <= 46'(sysp_reg * sr_reg);
            t5_reg    <= 46'(sysp_reg * cr_reg);
            cycp2_reg <= cycp_reg;
            sycp2_reg <= sycp_reg;
            sycr2_reg <= sycr_reg;
            sysr2_reg <= sysr_reg;
            cycr2_reg <= cycr_reg;
            cysr2_reg <= cysr_reg;
            cpsr2_reg <= cpsr_reg;
            cpcr2_reg <= cpcr_reg;
            sp2_reg   <= sp_reg;
        end
    end

    function automatic logic signed [TrigW-1:0] fin(input logic signed [46:0] v);
        logic signed [46:0] t;
        t = (v + 47'sd134217728) >>> 28;
        if (t > 47'sd16384)       fin = Q14One;
        else if (t < -47'sd16384) fin = -Q14One;
        else                      fin = t[TrigW-1:0];
    endfunction

    function automatic logic signed [46:0] al(input logic signed [29:0] p);
        al = {{3{p[29]}}, p, 14'd0};
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0] <= fin(al(cycp2_reg));
            r_reg[1] <= fin(47'(t1_reg) - al(sycr2_reg));
            r_reg[2] <= fin(47'(t2_reg) + al(sysr2_reg));
            r_reg[3] <= fin(al(sycp2_reg));
            r_reg[4] <= fin(47'(t4_reg) + al(cycr2_reg));
            r_reg[5] <= fin(47'(t5_reg) - al(cysr2_reg));
            r_reg[6] <= -sp2_reg;
            r_reg[7] <= fin(al(cpsr2_reg));
            r_reg[8] <= fin(al(cpcr2_reg));
        end
    end

    assign r_out = r_reg;

endmodule

[rtl/core/rpy_to_homogeneous_transform_core.sv]
// ----------------------------------------------------------------------------
// rpy_to_homogeneous_transform_core: pose to 3x4 transform
// Three CORDIC lanes compute sine and cosine of roll, pitch and yaw; a merge
// stage forms Rz*Ry*Rx; the translation travels alongside.
//
//   Channel | Direction | Payload
//   s_      | in        | rpyt_in_t  (pos_x..z, roll, pitch, yaw)
//   m_      | out       | rpyt_out_t (r00..r22, tx..tz)
//
// One request per cycle sustained unless m_ready stalls. A request passes
// each lane's input register, CORDIC_STAGES (capped at 24) rotation stages
// and rounding register, then the three merge stages. The pipeline advances
// as a whole when its last stage is empty or taken; a stall at m_ready holds
// every stage. Synchronous reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module rpy_to_homogeneous_transform_core
    import rpyt_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDefault
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  rpyt_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rpyt_out_t m_data
);

    localparam int NS  = (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;
    localparam int LAT = NS + 5;

    logic [LAT-1:0] vld_reg;
    logic           en;
    logic signed [31:0] tx_reg [0:LAT-1];
    logic signed [31:0] ty_reg [0:LAT-1];
    logic signed [31:0] tz_reg [0:LAT-1];
    rpyt_sc_t sc_r, sc_p, sc_y;
    logic signed [TrigW-1:0] r [0:8];

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    // Valid bits follow each request down the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Translation delay line.
    always_ff @(posedge aclk) begin
        if (en) begin
            tx_reg[0] <= s_data.pos_x;
            ty_reg[0] <= s_data.pos_y;
            tz_reg[0] <= s_data.pos_z;
            for (int k = 1; k < LAT; k++) begin
                tx_reg[k] <= tx_reg[k-1];
                ty_reg[k] <= ty_reg[k-1];
                tz_reg[k] <= tz_reg[k-1];
            end
        end
    end

    rpyt_cordic_lane #(.STAGES(CORDIC_STAGES)) u_roll (
        .aclk(aclk), .en(en), .angle(s_data.roll), .sc(sc_r));
    rpyt_cordic_lane #(.STAGES(CORDIC_STAGES)) u_pitch (
        .aclk(aclk), .en(en), .angle(s_data.pitch), .sc(sc_p));
    rpyt_cordic_lane #(.STAGES(CORDIC_STAGES)) u_yaw (
        .aclk(aclk), .en(en), .angle(s_data.yaw), .sc(sc_y));

    rpyt_merge u_merge (
        .aclk(aclk), .en(en), .sc_r(sc_r), .sc_p(sc_p), .sc_y(sc_y), .r_out(r));

    always_comb begin
        m_data.r00 = r[0];
        m_data.r01 = r[1];
        m_data.r02 = r[2];
        m_data.r10 = r[3];
        m_data.r11 = r[4];
        m_data.r12 = r[5];
        m_data.r20 = r[6];
        m_data.r21 = r[7];
        m_data.r22 = r[8];
        m_data.tx  = tx_reg[LAT-1];
        m_data.ty  = ty_reg[LAT-1];
        m_data.tz  = tz_reg[LAT-1];
    end

endmodule

[rtl/core/rpyt_checker.sv]
// ----------------------------------------------------------------------------
// rpyt_checker: port-level checks
// Watches the channels of the transform core for handshake and range slips.
// ----------------------------------------------------------------------------
module rpyt_checker
    import rpyt_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input rpyt_out_t m_data
);

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The input is never refused while the output side is free.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused with empty output");

    // No result right after reset.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");

    // Rotation entries r00 and r22 stay within plus or minus one.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.r00 <= Q14One && m_data.r00 >= -Q14One &&
                     m_data.r22 <= Q14One && m_data.r22 >= -Q14One))
        else $error("rotation entry out of range");

endmodule

bind rpy_to_homogeneous_transform_core rpyt_checker u_rpyt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));

[bench/rpy_to_homogeneous_transform_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpy_to_homogeneous_transform_core_tb: self-checking bench for the core
// Sends pose requests through the s_ channel and compares every transform on
// the m_ channel with a local CORDIC and matrix predictor, field by field.
// Directed rows come first, then random poses with random gaps and stalls.
// ----------------------------------------------------------------------------
module rpy_to_homogeneous_transform_core_tb
    import rpyt_pkg::*;
();

    localparam int NumRandom = 1900;
    localparam int Latency   = CordicStagesDefault + 5;
    localparam int IdleLimit = 20000;
    localparam int NumRows   = 22;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    rpyt_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    rpyt_out_t m_data;

    rpyt_out_t pending_xforms[$];
    int        errors;
    int        idle_cycles;
    bit        hold_sink;
    bit        sending_done;

    rpy_to_homogeneous_transform_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Arithmetic shift right with rounding toward minus infinity.
    function automatic longint shr_floor(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > 16384) begin
            return 16384;
        end else if (v < -16384) begin
            return -16384;
        end
        return v;
    endfunction

    function automatic longint atan_entry(input int i);
        longint tbl[24] = '{843314857, 497837829, 263043837, 133525159,
            67021687, 33543516, 16775851, 8388437, 4194283, 2097149,
            1048576, 524288, 262144, 131072, 65536, 32768, 16384, 8192,
            4096, 2048, 1024, 512, 256, 128};
        return tbl[i];
    endfunction

    // Sine and cosine of a Q2.13 angle, in Q1.14.
    function automatic void angle_sincos(input logic signed [15:0] ang,
                                         output longint s, output longint c);
        longint a, x, y, z, dx, dy;
        bit     flip;
        a    = longint'(ang) * 131072;
        flip = 1'b0;
        x    = 652032874;
        y    = 0;
        if (a > 1686629713) begin
            a = a - 64'sd3373259426;
            flip = 1'b1;
        end else if (a < -1686629713) begin
            a = a + 64'sd3373259426;
            flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < CordicStagesDefault && i < 24; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_entry(i);
            end else begin
                x = x + dx; y = y - dy; z = z + atan_entry(i);
            end
        end
        x = clamp_unit(shr_floor(x + 32768, 16));
        y = clamp_unit(shr_floor(y + 32768, 16));
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    // Q3.42 sum rounded half up to Q1.14.
    function automatic logic signed [15:0] round_q14(input longint v);
        return 16'(clamp_unit(shr_floor(v + (longint'(1) << 27), 28)));
    endfunction

    // Transform predicted for one pose request.
    function automatic rpyt_out_t pose_transform(input rpyt_in_t p);
        longint    sr, cr, sp, cp, sy, cy;
        rpyt_out_t t;
        angle_sincos(p.roll, sr, cr);
        angle_sincos(p.pitch, sp, cp);
        angle_sincos(p.yaw, sy, cy);
        t.r00 = round_q14(cy * cp * 16384);
        t.r01 = round_q14(cy * sp * sr - sy * cr * 16384);
        t.r02 = round_q14(cy * sp * cr + sy * sr * 16384);
        t.r10 = round_q14(sy * cp * 16384);
        t.r11 = round_q14(sy * sp * sr + cy * cr * 16384);
        t.r12 = round_q14(sy * sp * cr - cy * sr * 16384);
        t.r20 = 16'(-sp);
        t.r21 = round_q14(cp * sr * 16384);
        t.r22 = round_q14(cp * cr * 16384);
        t.tx  = p.pos_x;
        t.ty  = p.pos_y;
        t.tz  = p.pos_z;
        return t;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(10, 60);
        end
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0:       return 16'sd25736;
            1:       return -16'sd25736;
            2:       return 16'($urandom());
            default: return 16'($signed($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    // Send one request; the transform expected is queued as it is accepted.
    task automatic send_pose(input rpyt_in_t p, input bit has_known,
                             input rpyt_out_t known);
        rpyt_out_t want;
        want = pose_transform(p);
        if (has_known && want != known) begin
            $display("%0t: table row disagrees with predictor: exp %h act %h",
                     $time, known, want);
            errors++;
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        pending_xforms.push_back(has_known ? known : want);
    endtask

    // Directed table: one row per request, with a known result where trivial.
    rpyt_in_t  dir_pose[NumRows];
    bit        dir_known[NumRows];
    rpyt_out_t dir_xform[NumRows];

    task automatic fill_table();
        logic signed [15:0] angs[14] = '{0, 25736, -25736, 12868, -12868,
            12869, -12869, 6434, -6434, 32767, -32768, 1, -1, 25735};
        for (int k = 0; k < NumRows; k++) begin
            dir_known[k] = 1'b0;
            dir_pose[k] = '{pos_x: 32'($urandom()), pos_y: 32'($urandom()),
                pos_z: 32'($urandom()), roll: angs[k % 14],
                pitch: angs[(k + 5) % 14], yaw: angs[(k + 9) % 14]};
        end
        // Zero angles give the identity, the first row with extreme translations.
        dir_pose[0] = '{pos_x: 32'h7fffffff, pos_y: 32'h80000000, pos_z: 32'hffffffff,
            roll: 0, pitch: 0, yaw: 0};
        dir_known[0] = 1'b1;
        dir_xform[0] = '{r00: 16384, r01: 0, r02: 0, r10: 0, r11: 16384, r12: 0,
            r20: 0, r21: 0, r22: 16384, tx: 32'h7fffffff, ty: 32'h80000000,
            tz: 32'hffffffff};
        dir_pose[1] = '{pos_x: 0, pos_y: 32'h55555555, pos_z: 32'haaaaaaaa,
            roll: 0, pitch: 0, yaw: 0};
        dir_known[1] = 1'b1;
        dir_xform[1] = '{r00: 16384, r01: 0, r02: 0, r10: 0, r11: 16384, r12: 0,
            r20: 0, r21: 0, r22: 16384, tx: 0, ty: 32'h55555555, tz: 32'haaaaaaaa};
    endtask

    // Stimulus.
    initial begin
        rpyt_in_t p;
        int       hold_at;
        int       g;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        hold_sink    = 1'b0;
        sending_done = 1'b0;
        errors       = 0;
        fill_table();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int k = 0; k < NumRows; k++) begin
            send_pose(dir_pose[k], dir_known[k], dir_xform[k]);
            g = gap_len();
            if (g > 0) begin
                s_valid <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
        hold_at = $urandom_range(200, 1500);
        for (int n = 0; n < NumRandom; n++) begin
            p = '{pos_x: 32'($urandom()), pos_y: 32'($urandom()),
                pos_z: 32'($urandom()), roll: rand_angle(),
                pitch: rand_angle(), yaw: rand_angle()};
            if (n == hold_at) begin
                hold_sink <= 1'b1;
            end
            send_pose(p, 1'b0, '0);
            if (n == NumRandom / 2) begin
                // Drain completely before going on.
                s_valid <= 1'b0;
                wait (pending_xforms.size() == 0);
                @(posedge aclk);
            end else if (n % 300 < 150) begin
                g = gap_len();
                if (g > 0) begin
                    s_valid <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off while requests pile up.
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                hold_sink = 1'b0;
            end
            n = gap_len();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Result checking.
    always @(posedge aclk) begin
        rpyt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_xforms.size() == 0) begin
                $display("%0t: unexpected transform %h", $time, m_data);
                errors++;
            end else begin
                want = pending_xforms.pop_front();
                if (m_data.r00 !== want.r00) begin
                    $display("%0t: r00 exp %0d act %0d", $time, want.r00, m_data.r00);
                    errors++;
                end
                if (m_data.r01 !== want.r01) begin
                    $display("%0t: r01 exp %0d act %0d", $time, want.r01, m_data.r01);
                    errors++;
                end
                if (m_data.r02 !== want.r02) begin
                    $display("%0t: r02 exp %0d act %0d", $time, want.r02, m_data.r02);
                    errors++;
                end
                if (m_data.r10 !== want.r10) begin
                    $display("%0t: r10 exp %0d act %0d", $time, want.r10, m_data.r10);
                    errors++;
                end
                if (m_data.r11 !== want.r11) begin
                    $display("%0t: r11 exp %0d act %0d", $time, want.r11, m_data.r11);
                    errors++;
                end
                if (m_data.r12 !== want.r12) begin
                    $display("%0t: r12 exp %0d act %0d", $time, want.r12, m_data.r12);
                    errors++;
                end
                if (m_data.r20 !== want.r20) begin
                    $display("%0t: r20 exp %0d act %0d", $time, want.r20, m_data.r20);
                    errors++;
                end
                if (m_data.r21 !== want.r21) begin
                    $display("%0t: r21 exp %0d act %0d", $time, want.r21, m_data.r21);
                    errors++;
                end
                if (m_data.r22 !== want.r22) begin
                    $display("%0t: r22 exp %0d act %0d", $time, want.r22, m_data.r22);
                    errors++;
                end
                if (m_data.tx !== want.tx) begin
                    $display("%0t: tx exp %h act %h", $time, want.tx, m_data.tx);
                    errors++;
                end
                if (m_data.ty !== want.ty) begin
                    $display("%0t: ty exp %h act %h", $time, want.ty, m_data.ty);
                    errors++;
                end
                if (m_data.tz !== want.tz) begin
                    $display("%0t: tz exp %h act %h", $time, want.tz, m_data.tz);
                    errors++;
                end
            end
        end
    end

    // Watchdog and end of run.
    initial begin
        idle_cycles = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: timeout", $time);
                $display("CHECKS FAILED");
                $finish;
            end
            if (sending_done && pending_xforms.size() == 0) begin
                repeat (Latency * 3) @(posedge aclk);
                if (errors == 0) begin
                    $display("ALL CHECKS PASSED");
                end else begin
                    $display("CHECKS FAILED");
                end
                $finish;
            end
        end
    end

endmodule

[filelist.f]
rtl/core/rpyt_pkg.sv
rtl/core/rpyt_cordic_lane.sv
rtl/core/rpyt_merge.sv
rtl/core/rpy_to_homogeneous_transform_core.sv
rtl/core/rpyt_checker.sv
bench/rpy_to_homogeneous_transform_core_tb.sv
